FILE: rtl/core/utf2u8_pkg.sv
package utf2u8_pkg;

  // Detected input encoding, as reported with every result item
  typedef enum logic [2:0] {
    ENC_NONE  = 3'd0,
    ENC_UTF8  = 3'd1,
    ENC_U16BE = 3'd2,
    ENC_U16LE = 3'd3,
    ENC_U32BE = 3'd4,
    ENC_U32LE = 3'd5
  } enc_t;

  // What a queued command expands to after its leading error items
  typedef enum logic [1:0] {
    K_NONE = 2'd0,  // error items only
    K_CP   = 2'd1,  // one code point, 1 to 4 UTF-8 bytes
    K_RAW  = 2'd2,  // one byte passed through unchanged
    K_END  = 2'd3   // end-of-stream marker
  } kind_t;

  // Front-end sequencer states
  typedef enum logic [1:0] {
    F_ACCEPT = 2'd0,
    F_REPLAY = 2'd1,
    F_END    = 2'd2,
    F_FLUSH  = 2'd3
  } fstate_t;

  localparam int CP_W = 21;

  // One command between front and back
  typedef struct packed {
    kind_t             kind;
    logic [1:0]        nerr;  // error items sent before the payload
    logic [CP_W-1:0]   val;   // code point, or raw byte in the low bits
    enc_t              enc;
    logic              last;  // last command caused by its input item
  } cmd_t;

  // One result item from the back end
  typedef struct packed {
    logic [7:0] data;
    logic       bval;
    logic       err;
    logic       send;
    enc_t       enc;
    logic       last;
  } res_t;

  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam logic [CMDQ_AW:0] CMDQ_FULL = CMDQ_DEPTH[CMDQ_AW:0];

endpackage

FILE: rtl/core/utf2u8_front.sv
module utf2u8_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_byte,
  input  logic               in_eos,
  output logic               push_valid,
  input  logic               push_ready,
  output utf2u8_pkg::cmd_t   push_cmd
);

  localparam logic [5:0]  HI_TAG    = 6'b110110;   // 0xD800..0xDBFF
  localparam logic [5:0]  LO_TAG    = 6'b110111;   // 0xDC00..0xDFFF
  localparam logic [20:0] SUPP_BASE = 21'h10000;
  localparam logic [31:0] CP_MAX    = 32'h0010FFFF;

  utf2u8_pkg::fstate_t state_r, state_nxt;
  utf2u8_pkg::enc_t    mode_r, mode_nxt;
  logic [7:0]          hdr_r [4];
  logic [2:0]          hcnt_r, hcnt_nxt;
  logic [23:0]         ua_r, ua_nxt;
  logic [1:0]          ubc_r, ubc_nxt;
  logic [9:0]          hsb_r, hsb_nxt;
  logic                pend_r, pend_nxt;
  logic [1:0]          ridx_r, ridx_nxt;
  logic [1:0]          rlast_r, rlast_nxt;
  logic                rend_r, rend_nxt;
  logic                stg_v_r, stg_v_nxt;
  utf2u8_pkg::cmd_t    stg_r, stg_nxt;

  logic                accept;
  logic                hdr_we;
  logic                go;
  logic                fin_step;
  logic                end_step;
  logic [1:0]          nerr_end;
  utf2u8_pkg::enc_t    enc_end;
  logic [7:0]          sb;
  logic                flush_go;

  // decoder outputs
  logic                d_cv;
  utf2u8_pkg::kind_t   d_kind;
  logic [1:0]          d_nerr;
  logic [20:0]         d_val;
  logic [23:0]         d_ua;
  logic [1:0]          d_ubc;
  logic [9:0]          d_hsb;
  logic                d_pend;
  logic [15:0]         v16;
  logic [31:0]         v32;
  logic [20:0]         cp_pair;
  logic                is_hi;
  logic                is_lo;

  logic                s_cv;
  utf2u8_pkg::cmd_t    s_cmd;

  assign in_ready = (state_r == utf2u8_pkg::F_ACCEPT) && push_ready;
  assign accept   = in_ready && in_valid;
  assign hdr_we   = accept && !in_eos && (mode_r == utf2u8_pkg::ENC_NONE);

  // Pick the byte and kind of step taken this cycle
  always_comb begin
    go       = 1'b0;
    fin_step = 1'b0;
    end_step = 1'b0;
    nerr_end = 2'd0;
    enc_end  = mode_r;
    sb       = in_byte;
    unique case (state_r)
      utf2u8_pkg::F_ACCEPT: begin
        if (accept) begin
          if (!in_eos && (mode_r != utf2u8_pkg::ENC_NONE)) begin
            go       = 1'b1;
            fin_step = 1'b1;
          end else if (in_eos && (mode_r != utf2u8_pkg::ENC_NONE)) begin
            go       = 1'b1;
            fin_step = 1'b1;
            end_step = 1'b1;
            nerr_end = {1'b0, pend_r} + {1'b0, (ubc_r != 2'd0)};
          end else if (in_eos && (hcnt_r == 3'd0)) begin
            go       = 1'b1;
            fin_step = 1'b1;
            end_step = 1'b1;
            enc_end  = utf2u8_pkg::ENC_UTF8;
          end
        end
      end
      utf2u8_pkg::F_REPLAY: begin
        sb       = hdr_r[ridx_r];
        go       = push_ready;
        fin_step = !rend_r && (ridx_r == rlast_r);
      end
      utf2u8_pkg::F_END: begin
        go       = push_ready;
        fin_step = 1'b1;
        end_step = 1'b1;
      end
      utf2u8_pkg::F_FLUSH: begin
      end
      default: begin
      end
    endcase
  end

  // Decode one byte in the current encoding
  always_comb begin
    v16     = 16'd0;
    v32     = 32'd0;
    cp_pair = 21'd0;
    is_hi   = 1'b0;
    is_lo   = 1'b0;
    d_cv    = 1'b0;
    d_kind  = utf2u8_pkg::K_NONE;
    d_nerr  = 2'd0;
    d_val   = 21'd0;
    d_ua    = ua_r;
    d_ubc   = ubc_r;
    d_hsb   = hsb_r;
    d_pend  = pend_r;
    unique case (mode_r) inside
      utf2u8_pkg::ENC_U16BE, utf2u8_pkg::ENC_U16LE: begin
        if (ubc_r == 2'd0) begin
          d_ua  = {16'd0, sb};
          d_ubc = 2'd1;
        end else begin
          v16     = (mode_r == utf2u8_pkg::ENC_U16BE) ? {ua_r[7:0], sb} : {sb, ua_r[7:0]};
          d_ua    = 24'd0;
          d_ubc   = 2'd0;
          is_hi   = (v16[15:10] == HI_TAG);
          is_lo   = (v16[15:10] == LO_TAG);
          cp_pair = SUPP_BASE + {1'b0, hsb_r, v16[9:0]};
          if (pend_r) begin
            d_pend = 1'b0;
            d_hsb  = 10'd0;
            if (is_lo) begin
              d_cv   = 1'b1;
              d_kind = utf2u8_pkg::K_CP;
              d_val  = cp_pair;
            end else if (is_hi) begin
              d_pend = 1'b1;
              d_hsb  = v16[9:0];
              d_cv   = 1'b1;
              d_nerr = 2'd1;
            end else begin
              d_cv   = 1'b1;
              d_kind = utf2u8_pkg::K_CP;
              d_nerr = 2'd1;
              d_val  = {5'd0, v16};
            end
          end else if (is_hi) begin
            d_pend = 1'b1;
            d_hsb  = v16[9:0];
          end else if (is_lo) begin
            d_cv   = 1'b1;
            d_nerr = 2'd1;
          end else begin
            d_cv   = 1'b1;
            d_kind = utf2u8_pkg::K_CP;
            d_val  = {5'd0, v16};
          end
        end
      end
      utf2u8_pkg::ENC_U32BE, utf2u8_pkg::ENC_U32LE: begin
        if (ubc_r != 2'd3) begin
          if (mode_r == utf2u8_pkg::ENC_U32BE) begin
            d_ua = {ua_r[15:0], sb};
          end else begin
            case (ubc_r)
              2'd0:    d_ua[7:0]   = sb;
              2'd1:    d_ua[15:8]  = sb;
              default: d_ua[23:16] = sb;
            endcase
          end
          d_ubc = ubc_r + 2'd1;
        end else begin
          v32   = (mode_r == utf2u8_pkg::ENC_U32BE) ? {ua_r, sb} : {sb, ua_r};
          d_ua  = 24'd0;
          d_ubc = 2'd0;
          d_cv  = 1'b1;
          if (v32 > CP_MAX) begin
            d_nerr = 2'd1;
          end else begin
            d_kind = utf2u8_pkg::K_CP;
            d_val  = v32[20:0];
          end
        end
      end
      default: begin
        d_cv   = 1'b1;
        d_kind = utf2u8_pkg::K_RAW;
        d_val  = {13'd0, sb};
      end
    endcase
  end

  // Form the command of this step
  always_comb begin
    s_cv       = end_step ? 1'b1 : d_cv;
    s_cmd.kind = end_step ? utf2u8_pkg::K_END : d_kind;
    s_cmd.nerr = end_step ? nerr_end : d_nerr;
    s_cmd.val  = end_step ? 21'd0 : d_val;
    s_cmd.enc  = end_step ? enc_end : mode_r;
    s_cmd.last = 1'b0;
  end

  assign flush_go = go && fin_step && stg_v_r && s_cv;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      utf2u8_pkg::F_ACCEPT: begin
        if (hdr_we && (hcnt_r == 3'd3)) begin
          state_nxt = utf2u8_pkg::F_REPLAY;
        end else if (accept && in_eos && (mode_r == utf2u8_pkg::ENC_NONE) &&
                     (hcnt_r != 3'd0)) begin
          state_nxt = utf2u8_pkg::F_REPLAY;
        end
      end
      utf2u8_pkg::F_REPLAY: begin
        if (go && (ridx_r == rlast_r)) begin
          if (rend_r) begin
            state_nxt = utf2u8_pkg::F_END;
          end else begin
            state_nxt = flush_go ? utf2u8_pkg::F_FLUSH : utf2u8_pkg::F_ACCEPT;
          end
        end
      end
      utf2u8_pkg::F_END: begin
        if (go) begin
          state_nxt = flush_go ? utf2u8_pkg::F_FLUSH : utf2u8_pkg::F_ACCEPT;
        end
      end
      utf2u8_pkg::F_FLUSH: begin
        if (push_ready) begin
          state_nxt = utf2u8_pkg::F_ACCEPT;
        end
      end
      default: state_nxt = utf2u8_pkg::F_ACCEPT;
    endcase
  end

  // Push commands: hold one back while later steps of the item may still add one
  always_comb begin
    push_valid = 1'b0;
    push_cmd   = stg_r;
    stg_v_nxt  = stg_v_r;
    stg_nxt    = stg_r;
    if (state_r == utf2u8_pkg::F_FLUSH) begin
      push_valid = stg_v_r;
      if (push_ready) begin
        stg_v_nxt = 1'b0;
      end
    end else if (go) begin
      if (fin_step) begin
        if (stg_v_r) begin
          push_valid    = 1'b1;
          push_cmd.last = !s_cv;
          if (s_cv) begin
            stg_nxt      = s_cmd;
            stg_nxt.last = 1'b1;
          end else begin
            stg_v_nxt = 1'b0;
          end
        end else if (s_cv) begin
          push_valid    = 1'b1;
          push_cmd      = s_cmd;
          push_cmd.last = 1'b1;
        end
      end else if (s_cv) begin
        if (stg_v_r) begin
          push_valid    = 1'b1;
          push_cmd.last = 1'b0;
        end
        stg_nxt   = s_cmd;
        stg_v_nxt = 1'b1;
      end
    end
  end

  // Stream state updates
  always_comb begin
    mode_nxt  = mode_r;
    hcnt_nxt  = hcnt_r;
    ua_nxt    = ua_r;
    ubc_nxt   = ubc_r;
    hsb_nxt   = hsb_r;
    pend_nxt  = pend_r;
    ridx_nxt  = ridx_r;
    rlast_nxt = rlast_r;
    rend_nxt  = rend_r;
    if (hdr_we) begin
      if (hcnt_r == 3'd3) begin
        hcnt_nxt  = 3'd0;
        ridx_nxt  = 2'd0;
        rlast_nxt = 2'd3;
        rend_nxt  = 1'b0;
        if (hdr_r[0] == 8'd0) begin
          mode_nxt = (hdr_r[1] == 8'd0) ? utf2u8_pkg::ENC_U32BE : utf2u8_pkg::ENC_U16BE;
        end else if (hdr_r[1] == 8'd0) begin
          mode_nxt = (hdr_r[2] == 8'd0) ? utf2u8_pkg::ENC_U32LE : utf2u8_pkg::ENC_U16LE;
        end else begin
          mode_nxt = utf2u8_pkg::ENC_UTF8;
        end
      end else begin
        hcnt_nxt = hcnt_r + 3'd1;
      end
    end else if (accept && in_eos && (mode_r == utf2u8_pkg::ENC_NONE) &&
                 (hcnt_r != 3'd0)) begin
      // short stream: flush buffered bytes as UTF-8, then the marker
      mode_nxt  = utf2u8_pkg::ENC_UTF8;
      ridx_nxt  = 2'd0;
      rlast_nxt = hcnt_r[1:0] - 2'd1;
      rend_nxt  = 1'b1;
    end
    if (go && end_step) begin
      mode_nxt = utf2u8_pkg::ENC_NONE;
      hcnt_nxt = 3'd0;
      ua_nxt   = 24'd0;
      ubc_nxt  = 2'd0;
      hsb_nxt  = 10'd0;
      pend_nxt = 1'b0;
    end else if (go) begin
      ua_nxt   = d_ua;
      ubc_nxt  = d_ubc;
      hsb_nxt  = d_hsb;
      pend_nxt = d_pend;
      if ((state_r == utf2u8_pkg::F_REPLAY) && (ridx_r != rlast_r)) begin
        ridx_nxt = ridx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= utf2u8_pkg::F_ACCEPT;
      mode_r  <= utf2u8_pkg::ENC_NONE;
      hcnt_r  <= 3'd0;
      ua_r    <= 24'd0;
      ubc_r   <= 2'd0;
      hsb_r   <= 10'd0;
      pend_r  <= 1'b0;
      ridx_r  <= 2'd0;
      rlast_r <= 2'd0;
      rend_r  <= 1'b0;
      stg_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      hcnt_r  <= hcnt_nxt;
      ua_r    <= ua_nxt;
      ubc_r   <= ubc_nxt;
      hsb_r   <= hsb_nxt;
      pend_r  <= pend_nxt;
      ridx_r  <= ridx_nxt;
      rlast_r <= rlast_nxt;
      rend_r  <= rend_nxt;
      stg_v_r <= stg_v_nxt;
    end
  end

  // Header bytes and the held command need no reset
  always_ff @(posedge clk) begin
    if (hdr_we) begin
      hdr_r[hcnt_r[1:0]] <= in_byte;
    end
    stg_r <= stg_nxt;
  end

endmodule

FILE: rtl/core/utf2u8_cmdq.sv
module utf2u8_cmdq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  utf2u8_pkg::cmd_t   push_cmd,
  output logic               pop_valid,
  input  logic               pop_ready,
  output utf2u8_pkg::cmd_t   pop_cmd
);

  utf2u8_pkg::cmd_t                  mem_r [utf2u8_pkg::CMDQ_DEPTH];
  logic [utf2u8_pkg::CMDQ_AW-1:0]    wp_r, wp_nxt;
  logic [utf2u8_pkg::CMDQ_AW-1:0]    rp_r, rp_nxt;
  logic [utf2u8_pkg::CMDQ_AW:0]      cnt_r, cnt_nxt;
  logic                              do_push;
  logic                              do_pop;

  assign push_ready = (cnt_r != utf2u8_pkg::CMDQ_FULL);
  assign pop_valid  = (cnt_r != '0);
  assign pop_cmd    = mem_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Advance pointers and occupancy
  always_comb begin
    wp_nxt  = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_cmd;
    end
  end

endmodule

FILE: rtl/core/utf2u8_back.sv
module utf2u8_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  utf2u8_pkg::cmd_t   pop_cmd,
  output logic               out_valid,
  input  logic               out_ready,
  output utf2u8_pkg::res_t   out_res
);

  localparam logic [7:0] LEAD2 = 8'hC0;
  localparam logic [7:0] LEAD3 = 8'hE0;
  localparam logic [7:0] LEAD4 = 8'hF0;
  localparam logic [7:0] CONT  = 8'h80;

  logic               wv_r, wv_nxt;
  utf2u8_pkg::cmd_t   w_r, w_nxt;
  logic [1:0]         ecnt_r, ecnt_nxt;
  logic [1:0]         idx_r, idx_nxt;
  logic               ov_r, ov_nxt;
  utf2u8_pkg::res_t   o_r, o_nxt;

  logic               produce;
  logic               emit;
  logic               done;
  logic [1:0]         nb_last;
  logic [1:0]         grp;
  logic [7:0]         cp_byte;
  utf2u8_pkg::res_t   res;

  // Length of the code point in bytes, minus one
  always_comb begin
    if (w_r.val < 21'h80) begin
      nb_last = 2'd0;
    end else if (w_r.val < 21'h800) begin
      nb_last = 2'd1;
    end else if (w_r.val < 21'h10000) begin
      nb_last = 2'd2;
    end else begin
      nb_last = 2'd3;
    end
  end

  // Encode the current byte of the code point
  always_comb begin
    grp = nb_last - idx_r;
    if (idx_r == 2'd0) begin
      case (nb_last)
        2'd0:    cp_byte = {1'b0, w_r.val[6:0]};
        2'd1:    cp_byte = LEAD2 | {3'd0, w_r.val[10:6]};
        2'd2:    cp_byte = LEAD3 | {4'd0, w_r.val[15:12]};
        default: cp_byte = LEAD4 | {5'd0, w_r.val[20:18]};
      endcase
    end else begin
      case (grp)
        2'd0:    cp_byte = CONT | {2'd0, w_r.val[5:0]};
        2'd1:    cp_byte = CONT | {2'd0, w_r.val[11:6]};
        default: cp_byte = CONT | {2'd0, w_r.val[17:12]};
      endcase
    end
  end

  assign produce = wv_r && (!ov_r || out_ready);

  // Build the next result of the working command
  always_comb begin
    res.data = 8'd0;
    res.bval = 1'b0;
    res.err  = 1'b0;
    res.send = 1'b0;
    res.enc  = w_r.enc;
    res.last = 1'b0;
    emit     = 1'b1;
    done     = 1'b1;
    if (ecnt_r != 2'd0) begin
      res.err = 1'b1;
      done    = (ecnt_r == 2'd1) && (w_r.kind == utf2u8_pkg::K_NONE);
    end else begin
      unique case (w_r.kind)
        utf2u8_pkg::K_CP: begin
          res.data = cp_byte;
          res.bval = 1'b1;
          done     = (idx_r == nb_last);
        end
        utf2u8_pkg::K_RAW: begin
          res.data = w_r.val[7:0];
          res.bval = 1'b1;
        end
        utf2u8_pkg::K_END: begin
          res.send = 1'b1;
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
    res.last = w_r.last && done;
  end

  assign pop_ready = !wv_r || (produce && done);

  // Advance through the command, load the next one when it finishes
  always_comb begin
    wv_nxt   = wv_r;
    w_nxt    = w_r;
    ecnt_nxt = ecnt_r;
    idx_nxt  = idx_r;
    if (pop_ready && pop_valid) begin
      wv_nxt   = 1'b1;
      w_nxt    = pop_cmd;
      ecnt_nxt = pop_cmd.nerr;
      idx_nxt  = 2'd0;
    end else if (produce && done) begin
      wv_nxt = 1'b0;
    end else if (produce) begin
      if (ecnt_r != 2'd0) begin
        ecnt_nxt = ecnt_r - 2'd1;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  // Output register: load a new result or drop the one taken
  always_comb begin
    ov_nxt = ov_r;
    o_nxt  = o_r;
    if (produce && emit) begin
      ov_nxt = 1'b1;
      o_nxt  = res;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  assign out_valid = ov_r;
  assign out_res   = o_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wv_r   <= 1'b0;
      ov_r   <= 1'b0;
      ecnt_r <= 2'd0;
      idx_r  <= 2'd0;
    end else begin
      wv_r   <= wv_nxt;
      ov_r   <= ov_nxt;
      ecnt_r <= ecnt_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r <= w_nxt;
    o_r <= o_nxt;
  end

endmodule

FILE: rtl/core/utf16_utf32_to_utf8_transcoder.sv
// Byte-stream to UTF-8 transcoder with JSON-style encoding detection. Each input item
// is one raw byte, or an end-of-stream mark (in_tlast high, data ignored). The first
// four bytes of a stream are buffered; their zero pattern selects UTF-32BE, UTF-16BE,
// UTF-32LE, UTF-16LE or UTF-8, and they are then decoded like any other bytes. Each
// result item is one UTF-8 byte, an error item (invalid surrogate, value above
// 0x10FFFF, unit cut off at the end) or the end marker that closes the stream and
// returns the block to its reset state; out_tlast marks the last result of an input
// item. Ordinary bytes enter at one item per cycle while the command queue has room.
// The fourth header byte, and a short-stream end, hold the input while the front end
// replays the buffered bytes one per cycle while the queue has room and pushes the
// last command of the item. The back end emits one result per cycle while its output
// is taken; an item makes 0 to 5 results (about 1.5 per byte for UTF-16 text); a
// four-entry command queue lets both ends stall on their own.
module utf16_utf32_to_utf8_transcoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // end_of_stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] utf8_byte
  output logic [5:0] out_tuser,  // [0] byte_valid, [1] error_flag, [2] stream_end,
                                 // [5:3] detected_encoding
  output logic       out_tlast   // last_of_run
);

  logic               push_valid;
  logic               push_ready;
  utf2u8_pkg::cmd_t   push_cmd;
  logic               pop_valid;
  logic               pop_ready;
  utf2u8_pkg::cmd_t   pop_cmd;
  utf2u8_pkg::res_t   res;

  utf2u8_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_byte    (in_tdata),
    .in_eos     (in_tlast),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  utf2u8_cmdq u_cmdq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  utf2u8_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  // Pack the result item onto the stream
  assign out_tdata = res.data;
  assign out_tuser = {res.enc, res.send, res.err, res.bval};
  assign out_tlast = res.last;

  // The end marker always closes its item's results
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tlast)
    else $error("end marker not flagged as last result");

  // A data byte is never an error or an end marker
  a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> !out_tuser[1] && !out_tuser[2])
    else $error("data byte carries error or end flag");

  // Every result is produced after an encoding is chosen
  a_enc_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser[5:3] != utf2u8_pkg::ENC_NONE)
    else $error("result reported with undecided encoding");

endmodule

FILE: dv/utf8_transcode_check.sv
module utf8_transcode_check (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tlast,
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,
  input  logic [5:0] out_tuser,
  input  logic       out_tlast,
  output int         fail_count,
  output int         outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PRINT_CAP = 50;

  // Results still owed by the block, oldest first
  utf2u8_pkg::res_t   utf8_due_q[$];
  utf2u8_pkg::res_t   got;
  utf2u8_pkg::res_t   want;

  // Shadow of the transcoder's stream state
  logic [7:0]         hdr_bytes [4];
  logic [2:0]         hdr_cnt;
  utf2u8_pkg::enc_t   cur_enc;
  logic [23:0]        unit_acc;
  logic [1:0]         unit_cnt;
  logic [9:0]         hi_bits;
  logic               hi_open;
  int                 made;

  task automatic report(input string what);
    fail_count++;
    if (fail_count <= PRINT_CAP) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Return to the start-of-stream state
  task automatic clear_stream();
    for (int k = 0; k < 4; k++) hdr_bytes[k] = 8'h00;
    hdr_cnt  = 3'd0;
    cur_enc  = utf2u8_pkg::ENC_NONE;
    unit_acc = 24'h0;
    unit_cnt = 2'd0;
    hi_bits  = 10'h0;
    hi_open  = 1'b0;
  endtask

  task automatic owe(input logic [7:0] d, input logic v, input logic e, input logic s);
    utf2u8_pkg::res_t r;
    r.data = d;
    r.bval = v;
    r.err  = e;
    r.send = s;
    r.enc  = cur_enc;
    r.last = 1'b0;
    utf8_due_q.push_back(r);
    made++;
  endtask

  task automatic owe_error();
    owe(8'h00, 1'b0, 1'b1, 1'b0);
  endtask

  // Split one code point into its UTF-8 bytes
  task automatic owe_code_point(input logic [20:0] cp);
    if (cp < 21'h80) begin
      owe(cp[7:0], 1'b1, 1'b0, 1'b0);
    end else if (cp < 21'h800) begin
      owe({3'b110, cp[10:6]}, 1'b1, 1'b0, 1'b0);
      owe({2'b10, cp[5:0]}, 1'b1, 1'b0, 1'b0);
    end else if (cp < 21'h10000) begin
      owe({4'b1110, cp[15:12]}, 1'b1, 1'b0, 1'b0);
      owe({2'b10, cp[11:6]}, 1'b1, 1'b0, 1'b0);
      owe({2'b10, cp[5:0]}, 1'b1, 1'b0, 1'b0);
    end else begin
      owe({5'b11110, cp[20:18]}, 1'b1, 1'b0, 1'b0);
      owe({2'b10, cp[17:12]}, 1'b1, 1'b0, 1'b0);
      owe({2'b10, cp[11:6]}, 1'b1, 1'b0, 1'b0);
      owe({2'b10, cp[5:0]}, 1'b1, 1'b0, 1'b0);
    end
  endtask

  // Pair surrogates; flag lone halves
  task automatic take_unit16(input logic [15:0] u);
    logic low_half;
    low_half = (u >= 16'hDC00) && (u <= 16'hDFFF);
    if (hi_open) begin
      hi_open = 1'b0;
      if (low_half) begin
        owe_code_point(21'h10000 + {1'b0, hi_bits, u[9:0]});
        hi_bits = 10'h0;
        return;
      end
      hi_bits = 10'h0;
      owe_error();
    end
    if (u >= 16'hD800 && u <= 16'hDBFF) begin
      hi_open = 1'b1;
      hi_bits = u[9:0];
    end else if (low_half) begin
      owe_error();
    end else begin
      owe_code_point({5'b0, u});
    end
  endtask

  // Feed one raw byte through the unit assembler of the current encoding
  task automatic take_raw(input logic [7:0] b);
    logic [31:0] word;
    case (cur_enc)
      utf2u8_pkg::ENC_U16BE, utf2u8_pkg::ENC_U16LE: begin
        if (unit_cnt == 2'd0) begin
          unit_acc = {16'h0, b};
          unit_cnt = 2'd1;
        end else begin
          word = (cur_enc == utf2u8_pkg::ENC_U16BE) ? {16'h0, unit_acc[7:0], b}
                                                    : {16'h0, b, unit_acc[7:0]};
          unit_acc = 24'h0;
          unit_cnt = 2'd0;
          take_unit16(word[15:0]);
        end
      end
      utf2u8_pkg::ENC_U32BE, utf2u8_pkg::ENC_U32LE: begin
        if (unit_cnt < 2'd3) begin
          if (cur_enc == utf2u8_pkg::ENC_U32BE) unit_acc = {unit_acc[15:0], b};
          else unit_acc = unit_acc | (24'(b) << (8 * unit_cnt));
          unit_cnt++;
        end else begin
          word = (cur_enc == utf2u8_pkg::ENC_U32BE) ? {unit_acc, b} : {b, unit_acc};
          unit_acc = 24'h0;
          unit_cnt = 2'd0;
          if (word > 32'h10FFFF) owe_error();
          else owe_code_point(word[20:0]);
        end
      end
      default: owe(b, 1'b1, 1'b0, 1'b0);
    endcase
  endtask

  // Work out every result one accepted item causes
  task automatic predict_item(input logic [7:0] b, input logic eos);
    made = 0;
    if (!eos) begin
      if (cur_enc == utf2u8_pkg::ENC_NONE) begin
        hdr_bytes[hdr_cnt[1:0]] = b;
        hdr_cnt++;
        if (hdr_cnt >= 3'd4) begin
          if (hdr_bytes[0] == 8'h00)
            cur_enc = (hdr_bytes[1] == 8'h00) ? utf2u8_pkg::ENC_U32BE : utf2u8_pkg::ENC_U16BE;
          else if (hdr_bytes[1] == 8'h00)
            cur_enc = (hdr_bytes[2] == 8'h00) ? utf2u8_pkg::ENC_U32LE : utf2u8_pkg::ENC_U16LE;
          else
            cur_enc = utf2u8_pkg::ENC_UTF8;
          hdr_cnt = 3'd0;
          for (int k = 0; k < 4; k++) take_raw(hdr_bytes[k]);
        end
      end else begin
        take_raw(b);
      end
    end else begin
      if (cur_enc == utf2u8_pkg::ENC_NONE) begin
        // short stream: flush what was buffered as UTF-8
        cur_enc = utf2u8_pkg::ENC_UTF8;
        for (int k = 0; k < hdr_cnt; k++) take_raw(hdr_bytes[k]);
      end else begin
        if (hi_open) owe_error();
        if (unit_cnt != 2'd0) owe_error();
      end
      owe(8'h00, 1'b0, 1'b0, 1'b1);
      clear_stream();
    end
    if (made > 0) utf8_due_q[utf8_due_q.size() - 1].last = 1'b1;
  endtask

  // Predict on input handshakes, compare on output handshakes
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_stream();
      utf8_due_q.delete();
      fail_count = 0;
    end else begin
      if (in_tvalid && in_tready) predict_item(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        got.data = out_tdata;
        got.bval = out_tuser[0];
        got.err  = out_tuser[1];
        got.send = out_tuser[2];
        got.enc  = utf2u8_pkg::enc_t'(out_tuser[5:3]);
        got.last = out_tlast;
        if (utf8_due_q.size() == 0) begin
          report($sformatf("unexpected item data=%02h user=%02h last=%0b",
                           out_tdata, out_tuser, out_tlast));
        end else begin
          want = utf8_due_q.pop_front();
          if (got.data !== want.data || got.bval !== want.bval || got.err !== want.err ||
              got.send !== want.send || got.enc !== want.enc || got.last !== want.last)
            report($sformatf({"got %02h v%0b e%0b s%0b enc%0d l%0b, ",
                              "want %02h v%0b e%0b s%0b enc%0d l%0b"},
                             got.data, got.bval, got.err, got.send, got.enc, got.last,
                             want.data, want.bval, want.err, want.send, want.enc,
                             want.last));
        end
      end
    end
    outstanding <= utf8_due_q.size();
  end

endmodule

FILE: dv/tb_utf16_utf32_to_utf8_transcoder.sv
module tb_utf16_utf32_to_utf8_transcoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 300;
  localparam int DRAIN_CYCLES = 24;

  // Stimulus encodings
  localparam int SRC_UTF8  = 0;
  localparam int SRC_U16BE = 1;
  localparam int SRC_U16LE = 2;
  localparam int SRC_U32BE = 3;
  localparam int SRC_U32LE = 4;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic [7:0] in_tdata   = 8'h00;
  logic       in_tlast   = 1'b0;
  logic       out_tready = 1'b0;
  logic       in_tready;
  logic       out_tvalid;
  logic [7:0] out_tdata;
  logic [5:0] out_tuser;
  logic       out_tlast;

  int         fail_count;
  int         outstanding;
  int         burst_left  = 0;
  int         items_sent  = 0;
  int         quiet       = 0;
  int         rcv_cycle   = 0;
  int         rcv_mode    = 0;
  logic [8:0] stream_q[$];  // {end_of_stream, byte}

  always #5 clk = ~clk;

  utf16_utf32_to_utf8_transcoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  utf8_transcode_check u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Stall the output on one of four ready patterns, each chosen anew at random
  always @(posedge clk) begin
    rcv_cycle <= rcv_cycle + 1;
    if (rcv_cycle % 80 == 0) rcv_mode <= $urandom_range(0, 3);
    case (rcv_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= 1'($urandom_range(0, 1));
      2:       out_tready <= (rcv_cycle % 4 == 0);
      default: out_tready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // End the run when neither channel moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Offer one item in bursts with random gaps; return at its acceptance
  task automatic send(input logic [7:0] b, input logic eos);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eos;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic put_byte(input logic [7:0] b);
    stream_q.push_back({1'b0, b});
  endtask

  // Close the stream; the data byte is ignored, so make it random
  task automatic put_end(input logic [7:0] junk);
    stream_q.push_back({1'b1, junk});
  endtask

  task automatic flush_stream();
    logic [8:0] it;
    while (stream_q.size() > 0) begin
      it = stream_q.pop_front();
      send(it[7:0], it[8]);
    end
  endtask

  task automatic put_unit16(input int src, input logic [15:0] u);
    if (src == SRC_U16BE) begin
      put_byte(u[15:8]);
      put_byte(u[7:0]);
    end else begin
      put_byte(u[7:0]);
      put_byte(u[15:8]);
    end
  endtask

  task automatic put_word32(input int src, input logic [31:0] w);
    if (src == SRC_U32BE) begin
      put_byte(w[31:24]);
      put_byte(w[23:16]);
      put_byte(w[15:8]);
      put_byte(w[7:0]);
    end else begin
      put_byte(w[7:0]);
      put_byte(w[15:8]);
      put_byte(w[23:16]);
      put_byte(w[31:24]);
    end
  endtask

  // Write one code point in the chosen encoding
  task automatic put_char(input int src, input logic [31:0] cp);
    logic [19:0] off;
    if (src == SRC_UTF8) begin
      // content passes through untouched: any 1 to 4 bytes will do
      repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(1, 255)));
    end else if (src == SRC_U32BE || src == SRC_U32LE) begin
      put_word32(src, cp);
    end else if (cp >= 32'h10000 && cp <= 32'h10FFFF) begin
      off = 20'(cp - 32'h10000);
      put_unit16(src, {6'b110110, off[19:10]});
      put_unit16(src, {6'b110111, off[9:0]});
    end else begin
      put_unit16(src, cp[15:0]);
    end
  endtask

  // One stream: mostly well-formed text, some noise and broken tails
  task automatic random_stream();
    int src;
    int nchar;
    int pick;
    logic [31:0] cp;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(0, 10)) put_byte(8'($urandom_range(0, 255)));
    end else begin
      src = $urandom_range(SRC_UTF8, SRC_U32LE);
      nchar = $urandom_range(2, 10);
      for (int k = 0; k < nchar; k++) begin
        pick = (k < 2) ? -1 : $urandom_range(0, 19);
        if (pick < 0)        cp = $urandom_range(1, 127);
        else if (pick <= 5)  cp = $urandom_range(0, 127);
        else if (pick <= 9)  cp = $urandom_range(32'h80, 32'h7FF);
        else if (pick <= 12) cp = $urandom_range(32'h800, 32'hFFFF);
        else if (pick <= 15) cp = $urandom_range(32'h10000, 32'h10FFFF);
        else if (pick == 16) cp = $urandom_range(32'hD800, 32'hDBFF);
        else if (pick == 17) cp = $urandom_range(32'hDC00, 32'hDFFF);
        else if (pick == 18) cp = $urandom_range(32'h110000, 32'hFFFFFFFF);
        else cp = 32'hFFFFFFFF;
        if (pick == 19) put_byte(8'($urandom_range(0, 255)));
        else put_char(src, cp);
      end
      // leave a unit cut short now and then
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(0, 255)));
    end
    put_end(8'($urandom_range(0, 255)));
    flush_stream();
  endtask

  initial begin
    int rand_start;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // empty stream
    put_end(8'h00);
    // short stream with both byte extremes
    put_byte(8'h00); put_byte(8'hFF); put_end(8'h00);
    // UTF-32BE: 'A', value above the Unicode range, unit cut off at the end
    put_word32(SRC_U32BE, 32'h41);
    put_word32(SRC_U32BE, 32'h110000);
    put_byte(8'h00); put_end(8'h00);
    // UTF-16LE: header ending in a high surrogate, pair, lone low, open high at end
    put_unit16(SRC_U16LE, 16'h0041);
    put_unit16(SRC_U16LE, 16'hD83D);
    put_unit16(SRC_U16LE, 16'hDE00);
    put_unit16(SRC_U16LE, 16'hDC00);
    put_unit16(SRC_U16LE, 16'hD83D);
    put_end(8'h00);
    flush_stream();

    rand_start = items_sent;
    while (items_sent - rand_start < RANDOM_ITEMS) random_stream();
    in_tvalid <= 1'b0;

    // drain, then give stray items a chance to show
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
